// ===== design/vdp_pkg.sv =====
// ----------------------------------------------------------------------------
// vdp_pkg: shared types, constants and helpers
// Fixed-point formats, sequencer states and saturating arithmetic for the
// oscillator step generator.
// ----------------------------------------------------------------------------
package vdp_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int VALUE_WIDTH     = 24;
  localparam int H_FRAC          = 16;
  localparam int H_WIDTH         = 16;
  localparam int COUNT_WIDTH     = 16;
  localparam int MU_WIDTH        = VALUE_WIDTH - 1;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [VALUE_WIDTH:0]   operand_t;
  typedef logic [VALUE_WIDTH-1:0]        mag_t;
  typedef logic [2*VALUE_WIDTH-1:0]      prod_t;
  typedef logic [MU_WIDTH-1:0]           mu_t;
  typedef logic [H_WIDTH-1:0]            step_h_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;

  localparam value_t VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // 1.0, clipped to the value range when the fraction leaves no room for it
  localparam value_t ONE = (FRAC_BITS < VALUE_WIDTH - 1) ?
                           value_t'(64'(1) << FRAC_BITS) : VMAX;
  localparam mu_t MU_RESET = (FRAC_BITS < MU_WIDTH) ?
                             mu_t'(64'(1) << FRAC_BITS) : mu_t'(0);
  localparam step_h_t H_RESET     = step_h_t'(655);
  localparam count_t  COUNT_RESET = count_t'(1000);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_INIT_X     = 3'd0,
    REG_INIT_Y     = 3'd1,
    REG_DAMPING_MU = 3'd2,
    REG_STEP_H     = 3'd3,
    REG_STEP_COUNT = 3'd4
  } cfg_reg_e;

  // right shift applied to the product magnitude
  typedef enum logic [1:0] {
    SH_VALUE,
    SH_STEP,
    SH_HALF
  } shift_e;

  typedef struct packed {
    operand_t a;
    operand_t b;
    shift_e   sh;
  } mul_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M_XX,
    S_W_OM,
    S_M_T1,
    S_W_T1,
    S_M_T2,
    S_W_F,
    S_M_DY,
    S_W_YN,
    S_W_S,
    S_M_DX,
    S_W_X,
    S_DONE
  } seq_state_e;

  function automatic value_t sat_add(input value_t a, input value_t b);
    logic signed [VALUE_WIDTH:0] s;
    begin
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
        return s[VALUE_WIDTH] ? VMIN : VMAX;
      end
      return s[VALUE_WIDTH-1:0];
    end
  endfunction

  function automatic value_t sat_sub(input value_t a, input value_t b);
    logic signed [VALUE_WIDTH:0] s;
    begin
      s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
        return s[VALUE_WIDTH] ? VMIN : VMAX;
      end
      return s[VALUE_WIDTH-1:0];
    end
  endfunction

endpackage

// ===== design/vdp_mul.sv =====
// ----------------------------------------------------------------------------
// vdp_mul: shared multiply, shift and saturate unit
// Sign-magnitude product registered once; shift and clip on the read side.
// ----------------------------------------------------------------------------
module vdp_mul import vdp_pkg::*; (
  input  logic     clk,
  input  mul_req_t req,
  output value_t   res
);

  logic   neg_in;
  mag_t   mag_a;
  mag_t   mag_b;
  prod_t  prod;
  logic   neg;
  shift_e sh;
  prod_t  shifted;
  logic   big;
  logic   exact;

  always_comb begin
    neg_in = req.a[VALUE_WIDTH] ^ req.b[VALUE_WIDTH];
    mag_a  = req.a[VALUE_WIDTH] ? mag_t'(-req.a) : mag_t'(req.a);
    mag_b  = req.b[VALUE_WIDTH] ? mag_t'(-req.b) : mag_t'(req.b);
  end

  always_ff @(posedge clk) begin
    prod <= prod_t'(mag_a) * prod_t'(mag_b);
    neg  <= neg_in;
    sh   <= req.sh;
  end

  always_comb begin
    case (sh)
      SH_VALUE: shifted = prod >> FRAC_BITS;
      SH_STEP:  shifted = prod >> H_FRAC;
      SH_HALF:  shifted = prod >> (H_FRAC + 1);
      default:  shifted = prod;
    endcase
    big   = |shifted[2*VALUE_WIDTH-1:VALUE_WIDTH-1];
    exact = (shifted == (prod_t'(1) << (VALUE_WIDTH - 1)));
    if (neg) begin
      res = (big && !exact) ? VMIN : value_t'(-shifted);
    end else begin
      res = big ? VMAX : value_t'(shifted);
    end
  end

endmodule

// ===== design/vdp_core.sv =====
// ----------------------------------------------------------------------------
// vdp_core: step sequencer and state registers
// Walks one explicit step through the shared multiplier, issue and write-back
// in turn, and holds the current point and step counter.
// ----------------------------------------------------------------------------
module vdp_core import vdp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     restart,
  input  value_t   init_x,
  input  value_t   init_y,
  input  mu_t      damping_mu,
  input  step_h_t  step_h,
  input  logic     out_free,
  input  value_t   mul_res,
  output mul_req_t mul_req,
  output logic     idle,
  output logic     done,
  output value_t   x_now,
  output value_t   y_now,
  output count_t   step_counter
);

  seq_state_e state;
  seq_state_e state_next;
  value_t     acc;
  value_t     aux;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) begin
        state_next = restart ? S_DONE : S_M_XX;
      end
      S_M_XX: state_next = S_W_OM;
      S_W_OM: state_next = S_M_T1;
      S_M_T1: state_next = S_W_T1;
      S_W_T1: state_next = S_M_T2;
      S_M_T2: state_next = S_W_F;
      S_W_F:  state_next = S_M_DY;
      S_M_DY: state_next = S_W_YN;
      S_W_YN: state_next = S_W_S;
      S_W_S:  state_next = S_M_DX;
      S_M_DX: state_next = S_W_X;
      S_W_X:  state_next = S_DONE;
      S_DONE: if (out_free) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_req = '{a: '0, b: '0, sh: SH_VALUE};
    idle    = 1'b0;
    done    = 1'b0;
    case (state)
      S_IDLE: idle = 1'b1;
      S_M_XX: mul_req = '{a: operand_t'(x_now), b: operand_t'(x_now), sh: SH_VALUE};
      S_M_T1: mul_req = '{a: operand_t'({1'b0, damping_mu}), b: operand_t'(acc),
                          sh: SH_VALUE};
      S_M_T2: mul_req = '{a: operand_t'(acc), b: operand_t'(y_now), sh: SH_VALUE};
      S_M_DY: mul_req = '{a: operand_t'({1'b0, step_h}), b: operand_t'(acc),
                          sh: SH_STEP};
      S_M_DX: mul_req = '{a: operand_t'({1'b0, step_h}), b: operand_t'(aux),
                          sh: SH_HALF};
      S_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_now        <= '0;
      y_now        <= '0;
      step_counter <= '0;
    end else begin
      case (state)
        S_IDLE: if (start && restart) begin
          x_now        <= init_x;
          y_now        <= init_y;
          step_counter <= '0;
        end
        S_W_X: begin
          x_now        <= sat_add(x_now, mul_res);
          step_counter <= step_counter + count_t'(1);
        end
        S_W_S: y_now <= acc;
        default: ;
      endcase
    end
  end

  // scratch: 1 - x*x, mu*(1 - x*x), slope, new y, then y + new y
  always_ff @(posedge clk) begin
    case (state)
      S_W_OM: acc <= sat_sub(ONE, mul_res);
      S_W_T1: acc <= mul_res;
      S_W_F:  acc <= sat_sub(mul_res, x_now);
      S_W_YN: acc <= sat_add(y_now, mul_res);
      S_W_S:  aux <= sat_add(y_now, acc);
      default: ;
    endcase
  end

endmodule

// ===== design/van_der_pol_step_generator.sv =====
// ----------------------------------------------------------------------------
// van_der_pol_step_generator: oscillator trajectory, one step per item
// Configuration registers, step sequencer, shared multiplier, output register.
// ----------------------------------------------------------------------------
// A restart item loads init_x/init_y and returns them as step 0 through the
// done state and the output register. Any other item advances one explicit
// step: the five products of a step run one after another through a single
// registered multiplier, each with an issue state and a write-back state,
// plus one state for the y sum. in_ready is high only while the sequencer
// is idle. The result sits in an output register, so the next item may be
// taken while a result still waits; a finished step waits in the sequencer
// until that register is free. The x and y values are signed Q7.16 and
// saturate at every sum and product. Write the configuration registers only
// while the block is idle.
module van_der_pol_step_generator import vdp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [VALUE_WIDTH-1:0]     cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       restart,
  output logic                       out_valid,
  input  logic                       out_ready,
  output value_t                     x_value,
  output value_t                     y_value,
  output count_t                     step_index,
  output logic                       last
);

  value_t   init_x;
  value_t   init_y;
  mu_t      damping_mu;
  step_h_t  step_h;
  count_t   step_count;
  mul_req_t mul_req;
  value_t   mul_res;
  logic     idle;
  logic     done;
  logic     start;
  logic     out_free;
  value_t   x_now;
  value_t   y_now;
  count_t   step_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_x     <= '0;
      init_y     <= ONE;
      damping_mu <= MU_RESET;
      step_h     <= H_RESET;
      step_count <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_X:     init_x     <= cfg_data;
        REG_INIT_Y:     init_y     <= cfg_data;
        REG_DAMPING_MU: damping_mu <= cfg_data[MU_WIDTH-1:0];
        REG_STEP_H:     step_h     <= cfg_data[H_WIDTH-1:0];
        REG_STEP_COUNT: step_count <= cfg_data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = idle;
  assign start    = in_valid && idle;
  assign out_free = !out_valid || out_ready;

  vdp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .restart      (restart),
    .init_x       (init_x),
    .init_y       (init_y),
    .damping_mu   (damping_mu),
    .step_h       (step_h),
    .out_free     (out_free),
    .mul_res      (mul_res),
    .mul_req      (mul_req),
    .idle         (idle),
    .done         (done),
    .x_now        (x_now),
    .y_now        (y_now),
    .step_counter (step_counter)
  );

  vdp_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .res (mul_res)
  );

  // load the output register when the step is finished and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      x_value    <= x_now;
      y_value    <= y_now;
      step_index <= step_counter;
      last       <= (step_counter == step_count - count_t'(1));
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !restart) |=> !in_ready)
    else $error("item accepted while a step was in progress");

  a_restart_step0: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && restart && !out_valid) |-> ##2
      (out_valid && step_index == '0))
    else $error("restart did not return step 0");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (last == (step_index == step_count - count_t'(1))))
    else $error("last flag disagrees with step index");

  a_advance_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !restart) |=> !$rose(out_valid))
    else $error("advance result appeared too early");

endmodule

// ===== verif/tb_van_der_pol_step_generator.sv =====
// ----------------------------------------------------------------------------
// tb_van_der_pol_step_generator: self-checking bench for the step generator
// Drives restart/advance items through the valid/ready port, keeps its own
// fixed-point model of the trajectory and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_van_der_pol_step_generator import vdp_pkg::*; ();

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     REPORT_LIMIT   = 10;
  localparam longint VAL_MAX        = longint'(VMAX);
  localparam longint VAL_MIN        = longint'(VMIN);
  localparam longint UNIT_Q         = longint'(ONE);
  localparam longint COUNT_MASK     = (longint'(1) << COUNT_WIDTH) - 1;

  typedef struct {
    value_t x;
    value_t y;
    count_t idx;
    logic   last_flag;
  } point_t;

  // trajectory model and store of expected points
  class step_scoreboard;
    longint      init_x_q, init_y_q, mu_q;
    longint      h_q, run_len_q;
    longint      x_now, y_now, step_no;
    point_t      expected[$];
    int unsigned errors, checked, items, reg_writes;

    function new();
      init_x_q  = 0;
      init_y_q  = UNIT_Q;
      mu_q      = longint'(MU_RESET);
      h_q       = longint'(H_RESET);
      run_len_q = longint'(COUNT_RESET);
      x_now     = 0;
      y_now     = 0;
      step_no   = 0;
    endfunction

    function longint clip(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
    endfunction

    // exact product, magnitude truncated by sh bits, then clipped
    function longint scaled_product(longint a, longint b, int sh);
      bit     neg;
      longint ua, ub, p;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      p   = (ua * ub) >> sh;
      if (neg) return (p > VAL_MAX + 1) ? VAL_MIN : -p;
      return (p > VAL_MAX) ? VAL_MAX : p;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                            logic [VALUE_WIDTH-1:0] data);
      value_t sv;
      sv = data;
      reg_writes++;
      case (idx)
        REG_INIT_X:     init_x_q  = sv;
        REG_INIT_Y:     init_y_q  = sv;
        REG_DAMPING_MU: mu_q      = longint'(data[MU_WIDTH-1:0]);
        REG_STEP_H:     h_q       = longint'(data[H_WIDTH-1:0]);
        REG_STEP_COUNT: run_len_q = longint'(data[COUNT_WIDTH-1:0]);
        default: ;
      endcase
    endfunction

    function void note_item(bit restart_bit);
      longint xx, om, t1, t2, slope, dy, yn, ysum, dx;
      point_t p;
      items++;
      if (restart_bit) begin
        x_now   = init_x_q;
        y_now   = init_y_q;
        step_no = 0;
      end else begin
        xx    = scaled_product(x_now, x_now, FRAC_BITS);
        om    = clip(UNIT_Q - xx);
        t1    = scaled_product(mu_q, om, FRAC_BITS);
        t2    = scaled_product(t1, y_now, FRAC_BITS);
        slope = clip(t2 - x_now);
        dy    = scaled_product(h_q, slope, H_FRAC);
        yn    = clip(y_now + dy);
        ysum  = clip(y_now + yn);
        dx    = scaled_product(h_q, ysum, H_FRAC + 1);
        x_now   = clip(x_now + dx);
        y_now   = yn;
        step_no = (step_no + 1) & COUNT_MASK;
      end
      p.x         = value_t'(x_now);
      p.y         = value_t'(y_now);
      p.idx       = count_t'(step_no);
      p.last_flag = (step_no == ((run_len_q - 1) & COUNT_MASK));
      expected.push_back(p);
    endfunction

    function void check_result(value_t x, value_t y, count_t idx, logic last_flag);
      point_t e;
      checked++;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: result with nothing expected: x=%0d y=%0d idx=%0d last=%0b",
                   x, y, idx, last_flag);
        return;
      end
      e = expected.pop_front();
      if (x !== e.x || y !== e.y || idx !== e.idx || last_flag !== e.last_flag) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: step %0d exp x=%0d y=%0d last=%0b, got x=%0d y=%0d idx=%0d last=%0b",
                   e.idx, e.x, e.y, e.last_flag, x, y, idx, last_flag);
      end
    endfunction

    function void close_out();
      if (expected.size() != 0) begin
        errors++;
        $display("ERROR: %0d expected results never arrived", expected.size());
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_INIT_X;
  logic [VALUE_WIDTH-1:0]     cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       restart = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  value_t                     x_value;
  value_t                     y_value;
  count_t                     step_index;
  logic                       last;

  step_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct = 0;
  int             idle_cycles = 0;

  van_der_pol_step_generator u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .x_value    (x_value),
    .y_value    (y_value),
    .step_index (step_index),
    .last       (last)
  );

  always #5 clk = ~clk;

  // result side: random stalls, checking and the watchdog
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(x_value, y_value, step_index, last);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // leaves cfg_we high so that back-to-back writes need no second assignment
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [VALUE_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  task automatic write_unmapped();
    for (int i = int'(REG_STEP_COUNT) + 1; i < (1 << CFG_INDEX_WIDTH); i++) begin
      write_reg(i[CFG_INDEX_WIDTH-1:0], mag_t'($urandom()));
    end
  endtask

  task automatic send_item(input bit restart_bit);
    if (in_valid && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    restart  <= restart_bit;
    do @(posedge clk); while (!in_ready);
    sb.note_item(restart_bit);
  endtask

  // hold off the sender until every expected point has come back
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    int v;
    case ($urandom_range(5))
      0: return VMAX;
      1: return VMIN;
      2, 3: begin
        v = int'($urandom_range(262144)) - 131072;
        return v[VALUE_WIDTH-1:0];
      end
      default: return mag_t'($urandom());
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_INIT_X, pick_value());
    write_reg(REG_INIT_Y, pick_value());
    write_reg(REG_DAMPING_MU, ($urandom_range(3) == 0) ? mag_t'($urandom()) :
                                                         mag_t'($urandom_range(196608)));
    case ($urandom_range(3))
      0:       write_reg(REG_STEP_H, mag_t'($urandom()));
      1:       write_reg(REG_STEP_H, mag_t'($urandom_range(1, 1024)));
      default: write_reg(REG_STEP_H, mag_t'($urandom_range(1, 65535)));
    endcase
    write_reg(REG_STEP_COUNT, ($urandom_range(4) == 0) ? mag_t'($urandom()) :
                                                         mag_t'($urandom_range(1, 60)));
    if ($urandom_range(3) == 0) write_unmapped();
    end_writes();
  endtask

  // mostly restart followed by a run of advances; some stray single items
  task automatic run_block(input int unsigned quota);
    int unsigned sent, run_len, pick;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        drain();
      end else if (pick < 10) begin
        send_item($urandom_range(1) == 1);
        sent++;
      end else begin
        send_item(1'b1);
        run_len = $urandom_range(1, 40);
        repeat (run_len) send_item(1'b0);
        sent += run_len + 1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration; advance before any restart stays at the origin
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    drain();

    // extremes: full-scale start, maximum mu and step, one-step run
    write_reg(REG_INIT_X, VMAX);
    write_reg(REG_INIT_Y, VMIN);
    write_reg(REG_DAMPING_MU, '1);
    write_reg(REG_STEP_H, 24'h00ffff);
    write_reg(REG_STEP_COUNT, 24'h000001);
    write_unmapped();
    end_writes();
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    drain();

    // zero step freezes the point; stepping goes on past the run end
    write_reg(REG_INIT_X, VMIN);
    write_reg(REG_INIT_Y, VMAX);
    write_reg(REG_DAMPING_MU, 24'h000000);
    write_reg(REG_STEP_H, 24'hff0000);
    write_reg(REG_STEP_COUNT, 24'hff0003);
    end_writes();
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    drain();

    // smallest step, zero run length, mid-range start
    write_reg(REG_INIT_X, 24'h018000);
    write_reg(REG_INIT_Y, 24'h000000);
    write_reg(REG_DAMPING_MU, 24'h020000);
    write_reg(REG_STEP_H, 24'h000001);
    write_reg(REG_STEP_COUNT, 24'h000000);
    end_writes();
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    drain();

    // random part: four idling phases, three settings each
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        drain();
        random_config();
        run_block(103);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    sb.close_out();

    $display("Run covered %0d items and %0d checked results over %0d register writes,",
             sb.items, sb.checked, sb.reg_writes);
    $display("with directed extremes, runs past the end and four idling phases.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
